@@ rtl/core/dvng_pkg.sv @@
// Shared types and constants for the detection gating block.
// Used by the channel interfaces, the register file, the distance unit,
// the sequencer and the top level.
package dvng_pkg;

  // Default sizing of the zone table and of a detection run
  localparam int MAX_ZONES_DEF = 16;
  localparam int MAX_RUN_DEF   = 64;

  // Field widths
  localparam int CRD_W  = 24;  // coordinate, 1/256 m, signed
  localparam int RAD_W  = 23;  // radius or distance, unsigned
  localparam int IDX_W  = 6;   // reported index within a run
  localparam int MAG_W  = 25;  // magnitude of a coordinate difference
  localparam int DIST_W = 2 * MAG_W;  // sum of three squared axes
  localparam int RSQ_W  = 2 * RAD_W;  // squared radius

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic [RAD_W-1:0]        rad_t;

  // Radius that switches the search sphere off
  localparam rad_t RAD_UNLIMITED = '1;

  typedef enum logic [1:0] {
    REQ_DETECT   = 2'd0,
    REQ_ADD_ZONE = 2'd1,
    REQ_CLEAR    = 2'd2,
    REQ_NOP      = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_HEIGHT_MIN    = 3'd0,
    REG_HEIGHT_MAX    = 3'd1,
    REG_GATE_DISTANCE = 3'd2,
    REG_AREA_CX       = 3'd3,
    REG_AREA_CY       = 3'd4,
    REG_AREA_CZ       = 3'd5,
    REG_AREA_RADIUS   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    crd_t height_min;
    crd_t height_max;
    rad_t gate_distance;
    crd_t area_cx;
    crd_t area_cy;
    crd_t area_cz;
    rad_t area_radius;
  } cfg_t;

  typedef struct packed {
    crd_t cx;
    crd_t cy;
    crd_t cz;
    rad_t rad;
  } zone_t;

  // Request to the shared squared-distance unit
  typedef struct packed {
    logic start;
    crd_t ax;
    crd_t ay;
    crd_t az;
    crd_t bx;
    crd_t by;
    crd_t bz;
    rad_t rad;
  } sq_req_t;

  // Answer of the shared squared-distance unit
  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] sum;
    logic [RSQ_W-1:0]  rsq;
  } sq_rsp_t;

  typedef struct packed {
    logic             point_ok;
    logic             run_done;
    logic             found;
    crd_t             best_x;
    crd_t             best_y;
    crd_t             best_z;
    logic [IDX_W-1:0] best_index;
    logic             zone_dropped;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AREA_GO,
    ST_AREA_WT,
    ST_ZONE_RD,
    ST_ZONE_GO,
    ST_ZONE_WT,
    ST_REF_GO,
    ST_REF_WT,
    ST_EMIT
  } st_t;

endpackage

@@ rtl/core/dvng_if.sv @@
// Valid/ready channel interfaces for request items and result items.
// Depends on dvng_pkg for the field types.
interface dvng_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  dvng_pkg::crd_t          pos_x;
  dvng_pkg::crd_t          pos_y;
  dvng_pkg::crd_t          pos_z;
  dvng_pkg::rad_t          zone_radius_in;
  dvng_pkg::crd_t          ref_x;
  dvng_pkg::crd_t          ref_y;
  dvng_pkg::crd_t          ref_z;
  logic                    use_gate;
  logic                    run_last;

  modport source (
    output valid, req_type, pos_x, pos_y, pos_z, zone_radius_in,
           ref_x, ref_y, ref_z, use_gate, run_last,
    input  ready
  );
  modport sink (
    input  valid, req_type, pos_x, pos_y, pos_z, zone_radius_in,
           ref_x, ref_y, ref_z, use_gate, run_last,
    output ready
  );
endinterface

interface dvng_out_if;
  logic                          valid;
  logic                          ready;
  logic                          point_ok;
  logic                          run_done;
  logic                          found;
  dvng_pkg::crd_t                best_x;
  dvng_pkg::crd_t                best_y;
  dvng_pkg::crd_t                best_z;
  logic [dvng_pkg::IDX_W-1:0]    best_index;
  logic                          zone_dropped;

  modport source (
    output valid, point_ok, run_done, found, best_x, best_y, best_z,
           best_index, zone_dropped,
    input  ready
  );
  modport sink (
    input  valid, point_ok, run_done, found, best_x, best_y, best_z,
           best_index, zone_dropped,
    output ready
  );
endinterface

@@ rtl/core/dvng_regs.sv @@
// APB-style configuration registers: height bounds, gate distance, search sphere.
// Depends on dvng_pkg for the register map and the cfg_t bundle.
module dvng_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dvng_pkg::CFG_AW-1:0]   paddr,
  input  logic [dvng_pkg::CFG_DW-1:0]   pwdata,
  output logic [dvng_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output dvng_pkg::cfg_t                cfg
);

  localparam int CPAD = dvng_pkg::CFG_DW - dvng_pkg::CRD_W;
  localparam int RPAD = dvng_pkg::CFG_DW - dvng_pkg::RAD_W;

  dvng_pkg::cfg_t     cfg_r;
  dvng_pkg::cfg_t     cfg_nxt;
  dvng_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = dvng_pkg::reg_idx_t'(paddr[dvng_pkg::CFG_AW-1:2]);
  assign cfg    = cfg_r;

  // Decode a write into the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        dvng_pkg::REG_HEIGHT_MIN:    cfg_nxt.height_min    = pwdata[dvng_pkg::CRD_W-1:0];
        dvng_pkg::REG_HEIGHT_MAX:    cfg_nxt.height_max    = pwdata[dvng_pkg::CRD_W-1:0];
        dvng_pkg::REG_GATE_DISTANCE: cfg_nxt.gate_distance = pwdata[dvng_pkg::RAD_W-1:0];
        dvng_pkg::REG_AREA_CX:       cfg_nxt.area_cx       = pwdata[dvng_pkg::CRD_W-1:0];
        dvng_pkg::REG_AREA_CY:       cfg_nxt.area_cy       = pwdata[dvng_pkg::CRD_W-1:0];
        dvng_pkg::REG_AREA_CZ:       cfg_nxt.area_cz       = pwdata[dvng_pkg::CRD_W-1:0];
        dvng_pkg::REG_AREA_RADIUS:   cfg_nxt.area_radius   = pwdata[dvng_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.height_min    <= {1'b1, {(dvng_pkg::CRD_W-1){1'b0}}};
      cfg_r.height_max    <= {1'b0, {(dvng_pkg::CRD_W-1){1'b1}}};
      cfg_r.gate_distance <= '1;
      cfg_r.area_cx       <= '0;
      cfg_r.area_cy       <= '0;
      cfg_r.area_cz       <= '0;
      cfg_r.area_radius   <= dvng_pkg::RAD_UNLIMITED;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the raw register bits
  always_comb begin
    unique case (idx)
      dvng_pkg::REG_HEIGHT_MIN:    prdata = {{CPAD{1'b0}}, cfg_r.height_min};
      dvng_pkg::REG_HEIGHT_MAX:    prdata = {{CPAD{1'b0}}, cfg_r.height_max};
      dvng_pkg::REG_GATE_DISTANCE: prdata = {{RPAD{1'b0}}, cfg_r.gate_distance};
      dvng_pkg::REG_AREA_CX:       prdata = {{CPAD{1'b0}}, cfg_r.area_cx};
      dvng_pkg::REG_AREA_CY:       prdata = {{CPAD{1'b0}}, cfg_r.area_cy};
      dvng_pkg::REG_AREA_CZ:       prdata = {{CPAD{1'b0}}, cfg_r.area_cz};
      dvng_pkg::REG_AREA_RADIUS:   prdata = {{RPAD{1'b0}}, cfg_r.area_radius};
      default:                     prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/dvng_sqdist.sv @@
// Shared squared-distance unit: one subtract-and-square per cycle over x, y, z
// and the radius; yields the squared distance and the squared radius.
// Depends on dvng_pkg for sq_req_t and sq_rsp_t.
module dvng_sqdist (
  input  logic              clk,
  input  logic              rst_n,
  input  dvng_pkg::sq_req_t req,
  output dvng_pkg::sq_rsp_t rsp
);

  localparam int MW = dvng_pkg::MAG_W;
  localparam int DW = dvng_pkg::DIST_W;

  localparam logic [2:0] STEP_X    = 3'd0;
  localparam logic [2:0] STEP_Y    = 3'd1;
  localparam logic [2:0] STEP_Z    = 3'd2;
  localparam logic [2:0] STEP_R    = 3'd3;
  localparam logic [2:0] STEP_RSQ  = 3'd4;
  localparam logic [2:0] STEP_DONE = 3'd5;

  function automatic logic [MW-1:0] abs_diff(dvng_pkg::crd_t a, dvng_pkg::crd_t b);
    logic signed [MW-1:0] d;
    d = $signed({a[dvng_pkg::CRD_W-1], a}) - $signed({b[dvng_pkg::CRD_W-1], b});
    return d[MW-1] ? MW'(-d) : MW'(d);
  endfunction

  dvng_pkg::sq_req_t op_r;
  logic              busy_r, busy_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [MW-1:0]     mag_r, mag_nxt;
  logic [DW-1:0]     sq_r, sq_nxt;
  logic [DW-1:0]     acc_r, acc_nxt;

  // Sequence the four operands through the subtract, square and accumulate stages
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_X;
    end else if (busy_r) begin
      if (step_r == STEP_DONE) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end

    case (step_r)
      STEP_X:  mag_nxt = abs_diff(op_r.ax, op_r.bx);
      STEP_Y:  mag_nxt = abs_diff(op_r.ay, op_r.by);
      STEP_Z:  mag_nxt = abs_diff(op_r.az, op_r.bz);
      STEP_R:  mag_nxt = MW'(op_r.rad);
      default: mag_nxt = mag_r;
    endcase

    sq_nxt = mag_r * mag_r;

    case (step_r)
      STEP_Z:             acc_nxt = sq_r;
      STEP_R, STEP_RSQ:   acc_nxt = acc_r + sq_r;
      default:            acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_X;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath: latch operands on start, run the stages every cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req;
    end
    mag_r <= mag_nxt;
    sq_r  <= sq_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done = busy_r && (step_r == STEP_DONE);
  assign rsp.sum  = acc_r;
  assign rsp.rsq  = sq_r[dvng_pkg::RSQ_W-1:0];

endmodule

@@ rtl/core/dvng_ctrl.sv @@
// Sequencer: zone table, validity checks, nearest-point tracking per run and
// the result register. Drives the shared distance unit; depends on dvng_pkg
// and the dvng_in_if / dvng_out_if channel interfaces.
module dvng_ctrl #(
  parameter int MAX_ZONES = dvng_pkg::MAX_ZONES_DEF,
  parameter int MAX_RUN   = dvng_pkg::MAX_RUN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  dvng_in_if.sink           in_req,
  dvng_out_if.source        out_res,
  input  dvng_pkg::cfg_t    cfg,
  output dvng_pkg::sq_req_t sq_req,
  input  dvng_pkg::sq_rsp_t sq_rsp
);

  localparam int ZW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int CW = $clog2(MAX_ZONES + 1);
  localparam int PW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int DW = dvng_pkg::DIST_W;

  localparam logic [CW-1:0] ZONE_FULL = CW'(MAX_ZONES);
  localparam logic [PW-1:0] POS_MAX   = PW'(MAX_RUN - 1);

  dvng_pkg::st_t  state_r, state_nxt;

  // Item being worked on
  dvng_pkg::crd_t px_r, py_r, pz_r, rx_r, ry_r, rz_r;
  logic           gate_r, last_r;
  logic           in_acc;

  logic           ok_r, ok_nxt;
  logic [CW-1:0]  zidx_r, zidx_nxt;
  logic [CW-1:0]  zcnt_r, zcnt_nxt;
  logic           zwe;

  // Zone table
  dvng_pkg::zone_t zmem [MAX_ZONES];
  dvng_pkg::zone_t zrd_r;

  // Run state
  logic [PW-1:0]  run_pos_r, run_pos_nxt;
  logic           have_r, have_nxt;
  logic [DW-1:0]  best_dist_r, best_dist_nxt;
  dvng_pkg::crd_t bx_r, by_r, bz_r, bx_nxt, by_nxt, bz_nxt;
  logic [PW-1:0]  best_idx_r, best_idx_nxt;

  // Result staging and output register
  dvng_pkg::res_t res_r, res_nxt;
  dvng_pkg::res_t out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  // Candidate run update from the reference distance
  logic           upd;
  logic [DW-1:0]  cand_dist;
  dvng_pkg::crd_t cand_x, cand_y, cand_z;
  logic [PW-1:0]  cand_idx;
  logic           cand_found;
  logic           height_ok;
  logic           ok_area, ok_zone;

  assign in_acc    = in_req.valid && in_req.ready;
  assign height_ok = (in_req.pos_z > cfg.height_min) && (in_req.pos_z < cfg.height_max);
  assign ok_area   = ok_r && (sq_rsp.sum < DW'(sq_rsp.rsq));
  assign ok_zone   = ok_r && !(sq_rsp.sum < DW'(sq_rsp.rsq));

  // Keep the first nearest valid point; with use_gate, gate it by the squared gate distance
  always_comb begin
    upd        = ok_r && (!have_r || (sq_rsp.sum < best_dist_r));
    cand_dist  = upd ? sq_rsp.sum : best_dist_r;
    cand_x     = upd ? px_r : bx_r;
    cand_y     = upd ? py_r : by_r;
    cand_z     = upd ? pz_r : bz_r;
    cand_idx   = upd ? run_pos_r : best_idx_r;
    cand_found = (have_r || upd) && !(gate_r && (cand_dist >= DW'(sq_rsp.rsq)));
  end

  // Sequencer: next state, run state and unit operands
  always_comb begin
    state_nxt     = state_r;
    ok_nxt        = ok_r;
    zidx_nxt      = zidx_r;
    zcnt_nxt      = zcnt_r;
    zwe           = 1'b0;
    run_pos_nxt   = run_pos_r;
    have_nxt      = have_r;
    best_dist_nxt = best_dist_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    bz_nxt        = bz_r;
    best_idx_nxt  = best_idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    in_req.ready  = 1'b0;

    sq_req.start = 1'b0;
    sq_req.ax    = px_r;
    sq_req.ay    = py_r;
    sq_req.az    = pz_r;
    sq_req.bx    = cfg.area_cx;
    sq_req.by    = cfg.area_cy;
    sq_req.bz    = cfg.area_cz;
    sq_req.rad   = cfg.area_radius;

    // Drop the result once taken
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      dvng_pkg::ST_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          res_nxt = '0;
          unique case (dvng_pkg::req_t'(in_req.req_type))
            dvng_pkg::REQ_DETECT: begin
              ok_nxt   = height_ok;
              zidx_nxt = '0;
              if (cfg.area_radius != dvng_pkg::RAD_UNLIMITED) begin
                state_nxt = dvng_pkg::ST_AREA_GO;
              end else if (!height_ok || (zcnt_r == '0)) begin
                state_nxt = dvng_pkg::ST_REF_GO;
              end else begin
                state_nxt = dvng_pkg::ST_ZONE_RD;
              end
            end
            dvng_pkg::REQ_ADD_ZONE: begin
              if (zcnt_r != ZONE_FULL) begin
                zwe      = 1'b1;
                zcnt_nxt = zcnt_r + 1'b1;
              end else begin
                res_nxt.zone_dropped = 1'b1;
              end
              state_nxt = dvng_pkg::ST_EMIT;
            end
            dvng_pkg::REQ_CLEAR: begin
              zcnt_nxt  = '0;
              state_nxt = dvng_pkg::ST_EMIT;
            end
            dvng_pkg::REQ_NOP: begin
              state_nxt = dvng_pkg::ST_EMIT;
            end
          endcase
        end
      end

      dvng_pkg::ST_AREA_GO: begin
        sq_req.start = 1'b1;
        state_nxt    = dvng_pkg::ST_AREA_WT;
      end

      dvng_pkg::ST_AREA_WT: begin
        if (sq_rsp.done) begin
          ok_nxt   = ok_area;
          zidx_nxt = '0;
          if (!ok_area || (zcnt_r == '0)) begin
            state_nxt = dvng_pkg::ST_REF_GO;
          end else begin
            state_nxt = dvng_pkg::ST_ZONE_RD;
          end
        end
      end

      dvng_pkg::ST_ZONE_RD: begin
        state_nxt = dvng_pkg::ST_ZONE_GO;
      end

      dvng_pkg::ST_ZONE_GO: begin
        sq_req.start = 1'b1;
        sq_req.bx    = zrd_r.cx;
        sq_req.by    = zrd_r.cy;
        sq_req.bz    = zrd_r.cz;
        sq_req.rad   = zrd_r.rad;
        state_nxt    = dvng_pkg::ST_ZONE_WT;
      end

      dvng_pkg::ST_ZONE_WT: begin
        if (sq_rsp.done) begin
          ok_nxt   = ok_zone;
          zidx_nxt = zidx_r + 1'b1;
          if (!ok_zone || (zidx_nxt == zcnt_r)) begin
            state_nxt = dvng_pkg::ST_REF_GO;
          end else begin
            state_nxt = dvng_pkg::ST_ZONE_RD;
          end
        end
      end

      dvng_pkg::ST_REF_GO: begin
        sq_req.start = 1'b1;
        sq_req.bx    = rx_r;
        sq_req.by    = ry_r;
        sq_req.bz    = rz_r;
        sq_req.rad   = cfg.gate_distance;
        state_nxt    = dvng_pkg::ST_REF_WT;
      end

      dvng_pkg::ST_REF_WT: begin
        if (sq_rsp.done) begin
          res_nxt.point_ok = ok_r;
          if (last_r) begin
            res_nxt.run_done = 1'b1;
            if (cand_found) begin
              res_nxt.found      = 1'b1;
              res_nxt.best_x     = cand_x;
              res_nxt.best_y     = cand_y;
              res_nxt.best_z     = cand_z;
              res_nxt.best_index = dvng_pkg::IDX_W'(cand_idx);
            end
            // Close the run
            have_nxt     = 1'b0;
            run_pos_nxt  = '0;
            best_idx_nxt = '0;
          end else begin
            have_nxt      = have_r || upd;
            best_dist_nxt = cand_dist;
            bx_nxt        = cand_x;
            by_nxt        = cand_y;
            bz_nxt        = cand_z;
            best_idx_nxt  = cand_idx;
            if (run_pos_r != POS_MAX) begin
              run_pos_nxt = run_pos_r + 1'b1;
            end
          end
          state_nxt = dvng_pkg::ST_EMIT;
        end
      end

      dvng_pkg::ST_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_res.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = dvng_pkg::ST_IDLE;
        end
      end

      default: state_nxt = dvng_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dvng_pkg::ST_IDLE;
      ok_r        <= 1'b0;
      zidx_r      <= '0;
      zcnt_r      <= '0;
      run_pos_r   <= '0;
      have_r      <= 1'b0;
      best_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ok_r        <= ok_nxt;
      zidx_r      <= zidx_nxt;
      zcnt_r      <= zcnt_nxt;
      run_pos_r   <= run_pos_nxt;
      have_r      <= have_nxt;
      best_idx_r  <= best_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r   <= in_req.pos_x;
      py_r   <= in_req.pos_y;
      pz_r   <= in_req.pos_z;
      rx_r   <= in_req.ref_x;
      ry_r   <= in_req.ref_y;
      rz_r   <= in_req.ref_z;
      gate_r <= in_req.use_gate;
      last_r <= in_req.run_last;
    end
    best_dist_r <= best_dist_nxt;
    bx_r        <= bx_nxt;
    by_r        <= by_nxt;
    bz_r        <= bz_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  // Zone table: write the next free entry, registered read of the current one
  always_ff @(posedge clk) begin
    if (zwe) begin
      zmem[zcnt_r[ZW-1:0]] <= '{cx: in_req.pos_x, cy: in_req.pos_y,
                                cz: in_req.pos_z, rad: in_req.zone_radius_in};
    end
    zrd_r <= zmem[zidx_r[ZW-1:0]];
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.point_ok     = out_r.point_ok;
  assign out_res.run_done     = out_r.run_done;
  assign out_res.found        = out_r.found;
  assign out_res.best_x       = out_r.best_x;
  assign out_res.best_y       = out_r.best_y;
  assign out_res.best_z       = out_r.best_z;
  assign out_res.best_index   = out_r.best_index;
  assign out_res.zone_dropped = out_r.zone_dropped;

`ifndef NO_ASSERTIONS
  a_zone_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    zcnt_r <= ZONE_FULL)
    else $error("zone count beyond table size");

  a_run_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_pos_r <= POS_MAX)
    else $error("run position beyond saturation");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != dvng_pkg::ST_IDLE))
    else $error("accepted item did not start work");

  a_zone_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dvng_pkg::ST_ZONE_GO) |-> (zidx_r < zcnt_r))
    else $error("zone read beyond filled entries");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sq_rsp.done |-> ((state_r == dvng_pkg::ST_AREA_WT) ||
                     (state_r == dvng_pkg::ST_ZONE_WT) ||
                     (state_r == dvng_pkg::ST_REF_WT)))
    else $error("distance unit finished outside a wait state");
`endif

endmodule

@@ rtl/core/detection_validate_nearest_gate_top.sv @@
// Detection gating top level over dvng_regs, dvng_sqdist and dvng_ctrl (dvng_pkg, dvng_if).
// A detection runs the search-sphere check (skipped with the radius unlimited), one check
// per stored zone and the reference distance; a failed check skips the zones left. Zone,
// clear and no-op items go straight to the result register. The next item is accepted in
// the cycle after a result load, and a result not yet taken holds the block until it leaves.
// Synchronous active-low reset empties the zone table and the run state.
module detection_validate_nearest_gate_top #(
  parameter int MAX_ZONES = dvng_pkg::MAX_ZONES_DEF,
  parameter int MAX_RUN   = dvng_pkg::MAX_RUN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dvng_in_if.sink                     in_req,
  dvng_out_if.source                  out_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dvng_pkg::CFG_AW-1:0] paddr,
  input  logic [dvng_pkg::CFG_DW-1:0] pwdata,
  output logic [dvng_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  dvng_pkg::cfg_t    cfg;
  dvng_pkg::sq_req_t sq_req;
  dvng_pkg::sq_rsp_t sq_rsp;

  // Configuration registers
  dvng_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Shared squared-distance unit
  dvng_sqdist u_sqdist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  // Sequencer with zone table and run tracking
  dvng_ctrl #(
    .MAX_ZONES (MAX_ZONES),
    .MAX_RUN   (MAX_RUN)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg     (cfg),
    .sq_req  (sq_req),
    .sq_rsp  (sq_rsp)
  );

endmodule
